[rtl/csvp_pkg.sv]
// ----------------------------------------------------------------------------
// csvp_pkg
// Shared types and constants of the CSV column projector.
// ----------------------------------------------------------------------------
package csvp_pkg;

  localparam int unsigned MaskW       = 64;
  localparam int unsigned MaxRowsW    = 16;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned ApbDataW    = 64;
  localparam int unsigned ApbAddrW    = 4;
  localparam int unsigned DefNumCols  = 64;
  localparam int unsigned DefQueueDep = 4;

  localparam logic [MaxRowsW-1:0] MaxRowsReset = 16'd1000;

  localparam logic [ByteW-1:0] ChLineFeed = 8'h0A;
  localparam logic [ByteW-1:0] ChComma    = 8'h2C;
  localparam logic [ByteW-1:0] ChHash     = 8'h23;

  // Register index as decoded from paddr bit 3.
  localparam logic RegColumnMask = 1'b0;
  localparam logic RegMaxRows    = 1'b1;

  typedef struct packed {
    logic [MaskW-1:0]    column_mask;
    logic [MaxRowsW-1:0] max_rows;
  } cfg_t;

endpackage

[rtl/csvp_regs.sv]
// ----------------------------------------------------------------------------
// csvp_regs
// APB-style register file holding the column mask and the row limit.
// ----------------------------------------------------------------------------
module csvp_regs
  import csvp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  logic [MaskW-1:0]    mask_q;
  logic [MaxRowsW-1:0] rows_q;
  logic                wr_en;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      rows_q <= MaxRowsReset;
    end else if (wr_en) begin
      case (reg_sel)
        RegColumnMask: mask_q <= pwdata[MaskW-1:0];
        RegMaxRows:    rows_q <= pwdata[MaxRowsW-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegColumnMask: prdata = ApbDataW'(mask_q);
      RegMaxRows:    prdata = ApbDataW'(rows_q);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.column_mask = mask_q;
  assign cfg_o.max_rows    = rows_q;

endmodule

[rtl/csvp_front.sv]
// ----------------------------------------------------------------------------
// csvp_front
// Line and column tracker: classifies each input byte and decides whether
// it produces an output byte.
// ----------------------------------------------------------------------------
module csvp_front
  import csvp_pkg::*;
#(
  parameter int unsigned NUM_COLUMNS = DefNumCols
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             file_start_i,
  input  logic             space_i,
  output logic             push_o,
  output logic [ByteW-1:0] push_byte_o
);

  localparam int unsigned ColW    = $clog2(NUM_COLUMNS + 1);
  localparam int unsigned MaskIdW = $clog2(MaskW);
  localparam logic [ColW-1:0] ColLast = ColW'(NUM_COLUMNS);

  typedef enum logic [1:0] {
    PhStart,
    PhProj,
    PhSkip
  } phase_e;

  phase_e              ph_q, ph_d, ph_f;
  logic [ColW-1:0]     ci_q, ci_d, ci_f;
  logic                fe_q, fe_d, fe_f;
  logic                hd_q, hd_d, hd_f;
  logic                iff_q, iff_d, iff_f;
  logic [MaxRowsW-1:0] rows_q, rows_d, rows_f;
  logic                emit;
  logic [ByteW-1:0]    emit_byte;
  logic                accept;

  function automatic logic col_kept(input logic [ColW-1:0] c, input logic [MaskW-1:0] m);
    logic [MaskIdW-1:0] idx;
    idx = MaskIdW'(c);
    return (c < ColLast) && m[idx];
  endfunction

  assign in_ready_o = space_i;
  assign accept     = in_valid_i && in_ready_o;

  // A new file restarts the line state before the byte itself is handled.
  always_comb begin
    hd_f   = file_start_i ? 1'b0 : hd_q;
    iff_f  = (file_start_i && hd_q) ? 1'b0 : iff_q;
    rows_f = file_start_i ? '0 : rows_q;
    ph_f   = file_start_i ? PhStart : ph_q;
    ci_f   = file_start_i ? '0 : ci_q;
    fe_f   = file_start_i ? 1'b0 : fe_q;
  end

  always_comb begin
    ph_d      = ph_f;
    ci_d      = ci_f;
    fe_d      = fe_f;
    hd_d      = hd_f;
    iff_d     = iff_f;
    rows_d    = rows_f;
    emit      = 1'b0;
    emit_byte = data_byte_i;

    if (ph_f == PhStart) begin
      ci_d = '0;
      fe_d = 1'b0;
      if (data_byte_i == ChHash) begin
        ph_d = PhSkip;
      end else if (!hd_f) begin
        hd_d = 1'b1;
        ph_d = iff_f ? PhProj : PhSkip;
      end else if (rows_f < cfg_i.max_rows) begin
        rows_d = rows_f + 1'b1;
        ph_d   = PhProj;
      end else begin
        ph_d = PhSkip;
      end
      if (ph_d == PhProj && col_kept('0, cfg_i.column_mask)) begin
        fe_d = 1'b1;
      end
    end

    if (data_byte_i == ChLineFeed) begin
      emit      = (ph_d == PhProj) && (cfg_i.column_mask != '0);
      emit_byte = ChLineFeed;
      ph_d      = PhStart;
    end else if (ph_d == PhProj) begin
      if (data_byte_i == ChComma) begin
        if (ci_d < ColLast) begin
          ci_d = ci_d + 1'b1;
        end
        if (col_kept(ci_d, cfg_i.column_mask)) begin
          emit      = fe_d;
          emit_byte = ChComma;
          fe_d      = 1'b1;
        end
      end else begin
        emit = col_kept(ci_d, cfg_i.column_mask);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PhStart;
      ci_q   <= '0;
      fe_q   <= 1'b0;
      hd_q   <= 1'b0;
      iff_q  <= 1'b1;
      rows_q <= '0;
    end else if (accept) begin
      ph_q   <= ph_d;
      ci_q   <= ci_d;
      fe_q   <= fe_d;
      hd_q   <= hd_d;
      iff_q  <= iff_d;
      rows_q <= rows_d;
    end
  end

  assign push_o      = accept && emit;
  assign push_byte_o = emit_byte;

endmodule

[rtl/csvp_queue.sv]
// ----------------------------------------------------------------------------
// csvp_queue
// Short first-in first-out queue between the tracker and the output stage.
// ----------------------------------------------------------------------------
module csvp_queue
  import csvp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefQueueDep
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [ByteW-1:0] push_byte_i,
  output logic             space_o,
  input  logic             pop_i,
  output logic             avail_o,
  output logic [ByteW-1:0] head_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  logic [ByteW-1:0] mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign space_o = (cnt_q != CntFull);
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && space_o;
  assign do_pop  = pop_i && avail_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[rtl/csvp_back.sv]
// ----------------------------------------------------------------------------
// csvp_back
// Output register stage that presents queued bytes on the output channel.
// ----------------------------------------------------------------------------
module csvp_back
  import csvp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             avail_i,
  input  logic [ByteW-1:0] head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o
);

  logic             valid_q;
  logic [ByteW-1:0] byte_q;
  logic             load;

  // The register is refilled from the queue whenever a byte is queued and the register is empty or its beat leaves now.
  assign load  = avail_i && (!valid_q || out_ready_i);
  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;

endmodule

[rtl/csv_column_projector_top.sv]
// ----------------------------------------------------------------------------
// csv_column_projector_top
// CSV column projection filter, one text byte per beat.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i/in_ready_o carry data_byte_i and file_start_i;
// file_start_i marks the first byte of each new file. Output channel:
// out_valid_o/out_ready_i carry out_byte_o, the kept field bytes, the comma
// separators and the newline that ends each kept line.
// The APB-style port holds column_mask at address 0x0 and max_rows at 0x8;
// write them only while the block is idle.
// An input byte is classified in the cycle it is accepted. Its output byte,
// if any, is written into the queue and then loaded into the output
// register, from which it is offered. One byte is taken per cycle for as
// long as the output side keeps up; the rate is set by the line tracker,
// which handles each byte in the cycle it is accepted.
// When the receiver stalls, output bytes collect in a short queue and
// in_ready_o falls once the queue is full, rising again as it drains.
// Reset clears the queue and line state, sets the mask to zero and the row
// limit to 1000; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module csv_column_projector_top
  import csvp_pkg::*;
#(
  parameter int unsigned NUM_COLUMNS = DefNumCols,
  parameter int unsigned QUEUE_DEPTH = DefQueueDep
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ByteW-1:0]    data_byte_i,
  input  logic                file_start_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ByteW-1:0]    out_byte_o
);

  cfg_t             cfg;
  logic             space, push, avail, pop;
  logic [ByteW-1:0] push_byte, head;

  csvp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  csvp_front #(
    .NUM_COLUMNS (NUM_COLUMNS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .file_start_i (file_start_i),
    .space_i      (space),
    .push_o       (push),
    .push_byte_o  (push_byte)
  );

  csvp_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_byte_i (push_byte),
    .space_o     (space),
    .pop_i       (pop),
    .avail_o     (avail),
    .head_o      (head)
  );

  csvp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o)
  );

endmodule

[rtl/csvp_checker.sv]
// ----------------------------------------------------------------------------
// csvp_checker
// Port-level checks of the CSV column projector, bound to the top level.
// ----------------------------------------------------------------------------
module csvp_checker
  import csvp_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [ApbAddrW-1:0] paddr,
  input logic [ApbDataW-1:0] pwdata,
  input logic [ApbDataW-1:0] prdata,
  input logic                pready,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [ByteW-1:0]    out_byte_o
);

  logic wr_mask, wr_rows;

  assign wr_mask = psel && penable && pwrite && pready && !paddr[3];
  assign wr_rows = psel && penable && pwrite && pready && paddr[3];

  // A stalled output beat keeps its byte.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o))
    else $error("output beat changed while stalled");

  // Nothing is offered while reset is applied.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // A written mask reads back on the next cycle.
  a_mask_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_mask ##1 !paddr[3] |-> prdata == $past(pwdata))
    else $error("column mask read-back mismatch");

  // Only the low sixteen bits of a row limit write are kept.
  a_rows_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_rows ##1 paddr[3] |-> prdata == ApbDataW'($past(pwdata[MaxRowsW-1:0])))
    else $error("row limit read-back mismatch");

endmodule

bind csv_column_projector_top csvp_checker u_csvp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o)
);
